// File: hdl/huffman_stream_decoder_macros.svh
// Assertion macros for the prefix-code decoder top level.
`ifndef HUFFMAN_STREAM_DECODER_MACROS_SVH
`define HUFFMAN_STREAM_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/hsd_pkg.sv
// Types and constants shared by the prefix-code decoder modules.
package hsd_pkg;

	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int SYM_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int ENTRY_W = CODE_W + LEN_W + SYM_W;

	// Request kinds on the input channel.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// Outcome of one table search.
	typedef struct packed {
		logic             done;
		logic             hit;
		logic [SYM_W-1:0] symbol;
	} hsd_scan_t;

endpackage

// File: hdl/huffman_stream_decoder.sv
// Top level of the prefix-code decoder: request intake, bit shifter and result output.
//
// Input channel s_*: a request with s_tuser low loads one code table slot; with s_tuser
// high it delivers one compressed byte, consumed most significant bit first. s_tlast
// marks the final byte, whose lowest set bit and the zeros below it are padding.
// Output channel m_*: one result per decoded symbol, then after the final byte an end
// result (m_tuser[0]) carrying the stream error flag (m_tuser[1]). m_tlast marks the
// last result caused by one request.
// A data byte is shifted out one bit at a time; each bit starts a search of the code
// table, one slot per cycle through the single RAM port, ending at the first matching
// slot or at the last slot. The next request is accepted only once the byte is done.
// One request is worked on at a time; s_tready is high only while the block is idle.
// Reset empties the table (all slots unused) and clears the collected bits and the
// error flag; the block is idle out of reset, ready to accept a request.
// A stalled receiver holds the result in the output register; decoding halts when a
// further result must be sent, and resumes once it is taken.
module huffman_stream_decoder #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index[7:0], entry_code[23:8], entry_length[28:24], entry_symbol[36:29],
	// data_byte[44:37], zero padding[47:45]
	input  logic [47:0] s_tdata,
	// operation[0]
	input  logic [0:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// symbol[7:0]
	output logic [7:0]  m_tdata,
	// end_marker[0], stream_error[1]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import hsd_pkg::*;

	`include "huffman_stream_decoder_macros.svh"

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(MAX_CODE_BITS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SHIFT  = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_RESULT = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]               state_q;
	logic [BYTE_W-1:0]        byte_q;
	logic [3:0]               left_q;
	logic                     fin_q;
	logic                     zero_q;
	logic [MAX_CODE_BITS-1:0] pend_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     err_q;
	logic                     hold_v_q;
	logic [SYM_W-1:0]         hold_sym_q;
	logic [SYM_W-1:0]         new_sym_q;
	logic                     m_valid_q;
	logic [SYM_W-1:0]         m_sym_q;
	logic                     m_end_q;
	logic                     m_err_q;
	logic                     m_last_q;

	logic                     accept;
	logic                     out_free;
	logic                     ld;
	logic [ENTRY_W-1:0]       ld_entry;
	logic                     scan_start;
	hsd_scan_t                scan_res;
	logic [2:0]               tz;
	logic                     push;
	logic [SYM_W-1:0]         push_sym;
	logic                     push_end;
	logic                     push_err;
	logic                     push_last;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Table load path.
	assign ld = accept && (s_tuser[0] == OP_LOAD)
		&& ({1'b0, s_tdata[7:0]} < 9'(TABLE_ENTRIES));
	assign ld_entry   = {s_tdata[36:29], s_tdata[28:24], s_tdata[23:8]};
	assign scan_start = (state_q == ST_SHIFT) && (left_q != 4'd0);

	hsd_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.ld_idx   (s_tdata[IDX_W-1:0]),
		.ld_entry (ld_entry),
		.start    (scan_start),
		.pend     (pend_q),
		.cnt      (cnt_q),
		.res      (scan_res)
	);

	// Position of the padding marker in a final byte.
	always_comb begin
		tz = 3'd0;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			if (s_tdata[37 + i]) begin
				tz = 3'(i);
			end
		end
	end

	// Selection of the result that goes to the output register this cycle.
	always_comb begin
		push      = 1'b0;
		push_sym  = hold_sym_q;
		push_end  = 1'b0;
		push_err  = 1'b0;
		push_last = 1'b0;
		if (out_free) begin
			priority if (state_q == ST_RESULT && hold_v_q) begin
				push = 1'b1;
			end else if (state_q == ST_FINISH && hold_v_q) begin
				push      = 1'b1;
				push_last = !fin_q;
			end else if (state_q == ST_FINISH && fin_q) begin
				push      = 1'b1;
				push_sym  = '0;
				push_end  = 1'b1;
				push_err  = err_q || (cnt_q != '0) || zero_q;
				push_last = 1'b1;
			end else begin
				push = 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_sym_q   <= '0;
			m_end_q   <= 1'b0;
			m_err_q   <= 1'b0;
			m_last_q  <= 1'b0;
		end else if (push) begin
			m_valid_q <= 1'b1;
			m_sym_q   <= push_sym;
			m_end_q   <= push_end;
			m_err_q   <= push_err;
			m_last_q  <= push_last;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Decode sequencer: one bit per pass, a table search for each bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			byte_q     <= '0;
			left_q     <= '0;
			fin_q      <= 1'b0;
			zero_q     <= 1'b0;
			pend_q     <= '0;
			cnt_q      <= '0;
			err_q      <= 1'b0;
			hold_v_q   <= 1'b0;
			hold_sym_q <= '0;
			new_sym_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser[0] == OP_DATA) begin
						byte_q <= s_tdata[44:37];
						fin_q  <= s_tlast;
						zero_q <= s_tlast && (s_tdata[44:37] == '0);
						if (!s_tlast) begin
							left_q <= 4'd8;
						end else if (s_tdata[44:37] == '0) begin
							left_q <= 4'd0;
						end else begin
							left_q <= 4'd7 - {1'b0, tz};
						end
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (left_q == 4'd0) begin
						state_q <= ST_FINISH;
					end else begin
						pend_q  <= {pend_q[MAX_CODE_BITS-2:0], byte_q[BYTE_W-1]};
						cnt_q   <= cnt_q + 1'b1;
						byte_q  <= byte_q << 1;
						left_q  <= left_q - 4'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						if (scan_res.hit) begin
							new_sym_q <= scan_res.symbol;
							pend_q    <= '0;
							cnt_q     <= '0;
							state_q   <= ST_RESULT;
						end else begin
							if (32'(cnt_q) >= 32'(MAX_CODE_BITS)) begin
								err_q  <= 1'b1;
								pend_q <= '0;
								cnt_q  <= '0;
							end
							state_q <= ST_SHIFT;
						end
					end
				end
				ST_RESULT: begin
					if (!hold_v_q) begin
						hold_v_q   <= 1'b1;
						hold_sym_q <= new_sym_q;
						state_q    <= ST_SHIFT;
					end else if (push) begin
						hold_sym_q <= new_sym_q;
						state_q    <= ST_SHIFT;
					end
				end
				ST_FINISH: begin
					if (hold_v_q) begin
						if (push) begin
							hold_v_q <= 1'b0;
						end
					end else if (fin_q) begin
						if (push) begin
							pend_q  <= '0;
							cnt_q   <= '0;
							err_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_sym_q;
	assign m_tuser  = {m_err_q, m_end_q};
	assign m_tlast  = m_last_q;

	`HSD_ASSERT_SAME(a_idle_no_hold, s_tready, !hold_v_q, "held symbol left behind at idle")
	`HSD_ASSERT_SAME(a_done_in_scan, scan_res.done, state_q == ST_SCAN, "search ended outside scan")
	`HSD_ASSERT_SAME(a_cnt_range, 1'b1, 32'(cnt_q) <= 32'(MAX_CODE_BITS), "bit count overflow")
	`HSD_ASSERT_NEXT(a_end_clears, push && push_end, cnt_q == '0 && !err_q,
		"stream state not cleared after end result")

endmodule

// File: hdl/hsd_ram.sv
// Generic single-port RAM with registered read data.
module hsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one word per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/hsd_table.sv
// Code table storage and the slot-by-slot search for a matching code.
module hsd_table #(
	parameter int TABLE_ENTRIES = 256,
	parameter int MAX_CODE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ld,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]    ld_idx,
	input  logic [hsd_pkg::ENTRY_W-1:0]         ld_entry,
	input  logic                                start,
	input  logic [MAX_CODE_BITS-1:0]            pend,
	input  logic [$clog2(MAX_CODE_BITS+1)-1:0]  cnt,
	output hsd_pkg::hsd_scan_t                  res
);
	import hsd_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CMP_W = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     run_q;
	logic [IDX_W-1:0]         addr_q;
	logic                     rd_s1;
	logic                     rd_last_s1;
	logic                     vld_s1;
	hsd_scan_t                res_q;
	logic [ENTRY_W-1:0]       rdata;
	logic [IDX_W-1:0]         ram_addr;
	logic [CODE_W-1:0]        e_code;
	logic [LEN_W-1:0]         e_len;
	logic [SYM_W-1:0]         e_sym;
	logic [CMP_W-1:0]         mask;
	logic                     match;
	logic                     addr_end;
	logic                     scan_end;

	assign ram_addr = ld ? ld_idx : addr_q;

	hsd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ld),
		.addr  (ram_addr),
		.wdata (ld_entry),
		.rdata (rdata)
	);

	// Compare the returned slot against the collected bits.
	assign e_code   = rdata[CODE_W-1:0];
	assign e_len    = rdata[CODE_W+LEN_W-1:CODE_W];
	assign e_sym    = rdata[ENTRY_W-1:CODE_W+LEN_W];
	assign mask     = ~({CMP_W{1'b1}} << cnt);
	assign match    = vld_s1 && (e_len != '0)
		&& (32'(e_len) <= 32'(MAX_CODE_BITS)) && (32'(e_len) == 32'(cnt))
		&& ((CMP_W'(e_code) & mask) == CMP_W'(pend));
	assign addr_end = (addr_q == IDX_W'(TABLE_ENTRIES - 1));
	assign scan_end = rd_s1 && (match || rd_last_s1);

	// Slot valid bits: cleared at reset, set by a load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ld) begin
			valid_q[ld_idx] <= 1'b1;
		end
	end

	// Search sequencer: one slot read per cycle, stop at the first hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			addr_q     <= '0;
			rd_s1      <= 1'b0;
			rd_last_s1 <= 1'b0;
			vld_s1     <= 1'b0;
			res_q      <= '0;
		end else begin
			res_q.done <= scan_end;
			if (scan_end) begin
				res_q.hit    <= match;
				res_q.symbol <= e_sym;
			end
			rd_s1 <= run_q && !start && !scan_end;
			if (start) begin
				run_q  <= 1'b1;
				addr_q <= '0;
			end else if (scan_end || (run_q && addr_end)) begin
				run_q <= 1'b0;
			end
			if (!start && run_q) begin
				rd_last_s1 <= addr_end;
				vld_s1     <= valid_q[addr_q];
				if (!addr_end) begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	assign res = res_q;

endmodule
